[src/stlb_pkg.sv]
// Package: shared constants and types for the sorted-table lower-bound block.
`timescale 1ns / 1ps
package stlb_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 64;
  localparam int POS_W = 11;

  // Item codes carried in the mode field.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic status;
  } result_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

[src/sorted_table_lower_bound.sv]
// Top level: sorted key table with clear, append and lower-bound query transactions.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low; every transaction
// returns exactly one result, shown on result for the single cycle in which done
// is high, and the receiver cannot stall it. Clear, append and unused codes
// answer in the cycle after they are taken and never raise busy, so they may be
// issued back to back. A query on an empty table also answers in the cycle after
// it is taken. Any other query raises busy and walks the key memory through its
// single read port, one probe per cycle: a check of the last entry, a check of
// the first entry, then one probe per halving of [0, entry_count). Done rises in
// the cycle in which busy falls. Keys must be appended in ascending order; an
// append to a full table of 1024 keys is dropped and returns status 1.
// No clearing pass runs after reset: only entries below the count are read.
module sorted_table_lower_bound
  import stlb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output result_t result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LAST  = 4'b0010,
    ST_FIRST = 4'b0100,
    ST_PROBE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] mid, mid_next;
  logic signed [KEY_W-1:0] key_q, key_next;
  logic done_next;
  result_t result_next;

  ram_wr_t wr;
  ram_rd_t rd;
  logic [KEY_W-1:0] rdata;

  // Probe step: narrow the interval by the entry just read.
  logic [CNT_W-1:0] lo_p, hi_p, mid_p;
  logic key_le;

  stlb_key_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  assign busy = (state != ST_IDLE);
  assign key_le = (key_q <= $signed(rdata));

  always_comb begin
    lo_p = lo;
    hi_p = hi;
    if (key_le) begin
      hi_p = mid;
    end else begin
      lo_p = mid + 1'b1;
    end
    mid_p = lo_p + ((hi_p - lo_p) >> 1);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    lo_next = lo;
    hi_next = hi;
    mid_next = mid;
    key_next = key_q;
    done_next = 1'b0;
    result_next = result;
    wr = '0;
    rd = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          key_next = cmd.key;
          result_next.status = 1'b0;
          case (cmd.mode)
            MODE_CLEAR: begin
              count_next = '0;
              done_next = 1'b1;
              result_next.position = '0;
            end
            MODE_APPEND: begin
              done_next = 1'b1;
              if (count < CNT_W'(TABLE_DEPTH)) begin
                wr.en = 1'b1;
                wr.addr = count[ADDR_W-1:0];
                wr.data = cmd.key;
                count_next = count + 1'b1;
                result_next.position = POS_W'(count + 1'b1);
              end else begin
                // Drop the key and flag the full table.
                result_next.position = POS_W'(count);
                result_next.status = 1'b1;
              end
            end
            MODE_QUERY: begin
              if (count == '0) begin
                done_next = 1'b1;
                result_next.position = '0;
              end else begin
                // Check the last entry first.
                rd.en = 1'b1;
                rd.addr = ADDR_W'(count - 1'b1);
                state_next = ST_LAST;
              end
            end
            default: begin
              done_next = 1'b1;
              result_next.position = POS_W'(count);
            end
          endcase
        end
      end

      ST_LAST: begin
        if (!key_le) begin
          done_next = 1'b1;
          result_next.position = POS_W'(count);
          state_next = ST_IDLE;
        end else begin
          rd.en = 1'b1;
          rd.addr = '0;
          state_next = ST_FIRST;
        end
      end

      ST_FIRST: begin
        if (key_le) begin
          done_next = 1'b1;
          result_next.position = '0;
          state_next = ST_IDLE;
        end else begin
          // Start halving over the whole interval.
          lo_next = '0;
          hi_next = count;
          mid_next = count >> 1;
          rd.en = 1'b1;
          rd.addr = ADDR_W'(count >> 1);
          state_next = ST_PROBE;
        end
      end

      ST_PROBE: begin
        lo_next = lo_p;
        hi_next = hi_p;
        if (lo_p < hi_p) begin
          mid_next = mid_p;
          rd.en = 1'b1;
          rd.addr = mid_p[ADDR_W-1:0];
        end else begin
          done_next = 1'b1;
          result_next.position = POS_W'(lo_p);
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    mid <= mid_next;
    key_q <= key_next;
    result <= result_next;
  end

endmodule

[src/stlb_key_ram.sv]
// Key table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module stlb_key_ram
  import stlb_pkg::*;
(
  input  logic clk,
  input  ram_wr_t wr,
  input  ram_rd_t rd,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

[src/stlb_checker.sv]
// Checker: port-level properties of the lower-bound table, bound to the top level.
`timescale 1ns / 1ps
module stlb_checker
  import stlb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input result_t result
);

  // A clear answers in the next cycle with an empty table.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode == MODE_CLEAR |=>
      done && result.position == '0 && !result.status)
    else $error("clear did not return position 0");

  // Everything but a query answers in the next cycle without raising busy.
  a_fast_items: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode != MODE_QUERY |=> done && !busy)
    else $error("non-query transaction did not finish in one cycle");

  // A query either answers at once or starts its search.
  a_query_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode == MODE_QUERY |=> busy || done)
    else $error("query neither answered nor started");

  // The end of a search always brings its result.
  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without a result");

  // Only appends can flag a full table.
  a_status_append: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode != MODE_APPEND |=> !result.status)
    else $error("status set on a transaction that is not an append");

endmodule

bind sorted_table_lower_bound stlb_checker u_stlb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
